>>> hw/rtl/pvc_pkg.sv
// ----------------------------------------------------------------------------
// Prefix varint codec package
// Shared widths, constants and types of the prefix-length varint codec.
// ----------------------------------------------------------------------------
`default_nettype none

package pvc_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned WORD_W      = 40;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [DATA_W-1:0] LIMIT_1B = 32'h0000_007f;
  localparam logic [DATA_W-1:0] LIMIT_2B = 32'h0000_3fff;
  localparam logic [DATA_W-1:0] LIMIT_3B = 32'h001f_ffff;
  localparam logic [DATA_W-1:0] LIMIT_4B = 32'h0fff_ffff;
  localparam logic [DATA_W-1:0] MASK_5B  = 32'hffff_ffff;

  localparam logic [DATA_W-1:0] PREFIX_2B = 32'h0000_8000;
  localparam logic [DATA_W-1:0] PREFIX_3B = 32'h00c0_0000;
  localparam logic [DATA_W-1:0] PREFIX_4B = 32'he000_0000;
  localparam logic [BYTE_W-1:0] PREFIX_5B = 8'hf0;

  typedef enum logic {
    JOB_ENC = 1'b0,
    JOB_DEC = 1'b1
  } job_kind_t;

  typedef enum logic {
    REG_DIRECTION   = 1'b0,
    REG_SIGNED_MODE = 1'b1
  } reg_idx_t;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  typedef struct packed {
    dir_t direction;
    logic signed_mode;
  } cfg_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  count;
    logic              trunc;
  } job_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic [DATA_W-1:0] out_value;
    logic              value_valid;
    logic [CNT_W-1:0]  byte_count;
    logic              truncated;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/pvc_if.sv
// ----------------------------------------------------------------------------
// Prefix varint codec channels
// Valid/ready channel interfaces for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pvc_in_if;
  import pvc_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] in_data;
  logic              end_marker;

  modport source (output valid, output in_data, output end_marker, input ready);
  modport sink   (input valid, input in_data, input end_marker, output ready);
endinterface

interface pvc_out_if;
  import pvc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic [DATA_W-1:0] out_value;
  logic              value_valid;
  logic [CNT_W-1:0]  byte_count;
  logic              truncated;
  logic              last;

  modport source (output valid, output out_byte, output byte_valid, output out_value,
                  output value_valid, output byte_count, output truncated,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input out_value,
                  input value_valid, input byte_count, input truncated,
                  input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/prefix_varint_codec.sv
// ----------------------------------------------------------------------------
// Prefix-length varint codec
// Encodes 32-bit values into 1 to 5 prefix-length code bytes, or decodes a
// byte stream back into values, with optional zigzag signed mapping.
//
// The input channel in_ch carries a value (encode) or one byte in the low
// eight bits of in_data (decode), plus an end marker used only when decoding.
// The result channel out_ch carries one code byte or one decoded value per
// transfer, with last set on the final result of each input item.
// Registers are written over the APB-style port: direction at address 0 and
// signed_mode at address 4; write them only while the block is idle.
// The first result of an item passes through the job queue and the output
// register after its input transfer. Decode takes one byte every cycle while
// the queue has room. Encode is paced by the back end, which emits one code
// byte per cycle while out_ch is ready; the two-entry job queue lets the
// next value be taken meanwhile. When the receiver stalls, the output
// register holds its result and the queue fills, after which in_ch.ready
// drops. Reset clears the registers, the decode state and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_varint_codec #(
  parameter int unsigned QUEUE_DEPTH = pvc_pkg::QUEUE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  pvc_in_if.sink                           in_ch,
  pvc_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pvc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [pvc_pkg::PDATA_W-1:0] pwdata,
  output logic [pvc_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);
  import pvc_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t reg_idx;
  logic     wr_en;
  logic     push;
  job_t     push_job;
  job_t     head;
  logic     head_valid;
  logic     pop;
  logic     full;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_DIRECTION:   cfg_nxt.direction   = dir_t'(pwdata[0]);
        REG_SIGNED_MODE: cfg_nxt.signed_mode = pwdata[0];
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DIRECTION:   prdata = {31'h0, cfg_r.direction};
      REG_SIGNED_MODE: prdata = {31'h0, cfg_r.signed_mode};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{direction: DIR_ENCODE, signed_mode: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pvc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .in_ch (in_ch),
    .full  (full),
    .push  (push),
    .job   (push_job)
  );

  pvc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  pvc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

>>> hw/rtl/pvc_front.sv
// ----------------------------------------------------------------------------
// Prefix varint codec front end
// Accepts input items, sizes encode values and runs the byte-wise decode state,
// and pushes one job per item that produces results.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pvc_pkg::cfg_t cfg,
  pvc_in_if.sink             in_ch,
  input  wire logic          full,
  output logic               push,
  output pvc_pkg::job_t      job
);
  import pvc_pkg::*;

  logic [CNT_W-1:0]  left_r, left_nxt;
  logic [CNT_W-1:0]  taken_r, taken_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;

  logic              accept;
  logic [BYTE_W-1:0] in_byte;
  logic [DATA_W-1:0] enc_val;
  logic [CNT_W-1:0]  enc_len;
  logic [WORD_W-1:0] enc_word;
  logic [CNT_W-1:0]  ones;
  logic              first;
  logic [DATA_W-1:0] d_acc;
  logic [CNT_W-1:0]  d_taken;
  logic [CNT_W-1:0]  d_left;
  logic [DATA_W-1:0] d_mask;
  logic [DATA_W-1:0] d_val;
  logic [DATA_W-1:0] d_out;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_byte     = in_ch.in_data[BYTE_W-1:0];
  assign first       = (taken_r == '0);

  always_comb begin
    if (cfg.signed_mode) begin
      enc_val = {in_ch.in_data[DATA_W-2:0], 1'b0} ^ {DATA_W{in_ch.in_data[DATA_W-1]}};
    end else begin
      enc_val = in_ch.in_data;
    end
    priority if (enc_val <= LIMIT_1B) begin
      enc_len = 3'd1;
    end else if (enc_val <= LIMIT_2B) begin
      enc_len = 3'd2;
    end else if (enc_val <= LIMIT_3B) begin
      enc_len = 3'd3;
    end else if (enc_val <= LIMIT_4B) begin
      enc_len = 3'd4;
    end else begin
      enc_len = 3'd5;
    end
    unique case (enc_len)
      3'd1:    enc_word = {8'h00, enc_val};
      3'd2:    enc_word = {8'h00, enc_val | PREFIX_2B};
      3'd3:    enc_word = {8'h00, enc_val | PREFIX_3B};
      3'd4:    enc_word = {8'h00, enc_val | PREFIX_4B};
      default: enc_word = {PREFIX_5B, enc_val};
    endcase
  end

  always_comb begin
    priority if (!in_byte[7]) begin
      ones = 3'd0;
    end else if (!in_byte[6]) begin
      ones = 3'd1;
    end else if (!in_byte[5]) begin
      ones = 3'd2;
    end else if (!in_byte[4]) begin
      ones = 3'd3;
    end else begin
      ones = 3'd4;
    end
    if (first) begin
      d_acc   = {24'h0, in_byte};
      d_taken = 3'd1;
      d_left  = ones;
    end else begin
      d_acc   = {acc_r[DATA_W-BYTE_W-1:0], in_byte};
      d_taken = taken_r + 3'd1;
      d_left  = left_r - 3'd1;
    end
    unique case (d_taken)
      3'd1:    d_mask = LIMIT_1B;
      3'd2:    d_mask = LIMIT_2B;
      3'd3:    d_mask = LIMIT_3B;
      3'd4:    d_mask = LIMIT_4B;
      default: d_mask = MASK_5B;
    endcase
    d_val = d_acc & d_mask;
    if (cfg.signed_mode) begin
      d_out = {1'b0, d_val[DATA_W-1:1]} ^ {DATA_W{d_val[0]}};
    end else begin
      d_out = d_val;
    end
  end

  always_comb begin
    left_nxt  = left_r;
    taken_nxt = taken_r;
    acc_nxt   = acc_r;
    push      = 1'b0;
    job.kind  = JOB_ENC;
    job.word  = enc_word;
    job.count = enc_len;
    job.trunc = 1'b0;
    if (cfg.direction == DIR_ENCODE) begin
      push = accept;
    end else if (in_ch.end_marker) begin
      push      = accept && !first;
      job.kind  = JOB_DEC;
      job.word  = '0;
      job.count = '0;
      job.trunc = 1'b1;
      if (accept) begin
        left_nxt  = '0;
        taken_nxt = '0;
        acc_nxt   = '0;
      end
    end else begin
      push      = accept && (d_left == '0);
      job.kind  = JOB_DEC;
      job.word  = {8'h00, d_out};
      job.count = d_taken;
      if (accept) begin
        if (d_left == '0) begin
          left_nxt  = '0;
          taken_nxt = '0;
          acc_nxt   = '0;
        end else begin
          left_nxt  = d_left;
          taken_nxt = d_taken;
          acc_nxt   = d_acc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      taken_r <= '0;
      acc_r   <= '0;
    end else begin
      left_r  <= left_nxt;
      taken_r <= taken_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pvc_queue.sv
// ----------------------------------------------------------------------------
// Prefix varint codec job queue
// Small first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_queue #(
  parameter int unsigned DEPTH = pvc_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pvc_pkg::job_t push_job,
  input  wire logic          pop,
  output pvc_pkg::job_t      head,
  output logic               head_valid,
  output logic               full
);
  import pvc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

  job_t              mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = (count_r == CNT_QW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_QW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pvc_back.sv
// ----------------------------------------------------------------------------
// Prefix varint codec back end
// Turns queued jobs into result transfers, one code byte or one decoded
// value per cycle while out_ch is ready, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pvc_pkg::job_t head,
  input  wire logic          head_valid,
  output logic               pop,
  pvc_out_if.source          out_ch
);
  import pvc_pkg::*;

  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              res_r;
  res_t              res_nxt;
  logic              advance;
  logic              is_last;
  logic [CNT_W-1:0]  sel;
  logic [BYTE_W-1:0] sel_byte;

  assign advance = !out_valid_r || out_ch.ready;
  assign is_last = (head.kind == JOB_DEC) || (idx_r == head.count - 3'd1);
  assign sel     = head.count - 3'd1 - idx_r;
  assign pop     = advance && head_valid && is_last;

  always_comb begin
    unique case (sel)
      3'd0:    sel_byte = head.word[7:0];
      3'd1:    sel_byte = head.word[15:8];
      3'd2:    sel_byte = head.word[23:16];
      3'd3:    sel_byte = head.word[31:24];
      3'd4:    sel_byte = head.word[39:32];
      default: sel_byte = '0;
    endcase
  end

  always_comb begin
    res_nxt       = res_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        idx_nxt = is_last ? '0 : idx_r + 3'd1;
        if (head.kind == JOB_ENC) begin
          res_nxt.out_byte    = sel_byte;
          res_nxt.byte_valid  = 1'b1;
          res_nxt.out_value   = '0;
          res_nxt.value_valid = 1'b0;
          res_nxt.byte_count  = head.count;
          res_nxt.truncated   = 1'b0;
        end else begin
          res_nxt.out_byte    = '0;
          res_nxt.byte_valid  = 1'b0;
          res_nxt.out_value   = head.word[DATA_W-1:0];
          res_nxt.value_valid = !head.trunc;
          res_nxt.byte_count  = head.count;
          res_nxt.truncated   = head.trunc;
        end
        res_nxt.last = is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = res_r.out_byte;
  assign out_ch.byte_valid  = res_r.byte_valid;
  assign out_ch.out_value   = res_r.out_value;
  assign out_ch.value_valid = res_r.value_valid;
  assign out_ch.byte_count  = res_r.byte_count;
  assign out_ch.truncated   = res_r.truncated;
  assign out_ch.last        = res_r.last;

endmodule

`default_nettype wire
